@@ rtl/ers_pkg.sv @@
`default_nettype none

package ers_pkg;

  // floor numbers as carried on the input and output words
  localparam int unsigned FLOOR_W    = 5;
  localparam int unsigned FLOORS_DEF = 16;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_UP    = 2'd1,
    DIR_DOWN  = 2'd2
  } dir_e;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_ARRIVED = 1'b1
  } ev_cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_PLAN = 1'b1
  } state_e;

  typedef struct packed {
    logic load;    // latch event, update request bits and car floor
    logic commit;  // run the planner, write state and result word
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_commit;  // result register free or being drained
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/ers_ctrl.sv @@
`default_nettype none

module ers_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ers_pkg::dp_status_t  status_i,
  output ers_pkg::ctrl_cmd_t   cmd_o
);
  import ers_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PLAN;
        end
      end
      ST_PLAN: begin
        // hold the plan until the previous word has left
        if (status_i.can_commit) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ers_datapath.sv @@
`default_nettype none

module ers_datapath #(
  parameter int unsigned FLOORS = ers_pkg::FLOORS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ers_pkg::ctrl_cmd_t           cmd_i,
  output ers_pkg::dp_status_t          status_o,
  input  wire                          ev_cmd_i,
  input  wire [ers_pkg::FLOOR_W-1:0]   ev_floor_i,
  output logic                         res_valid_o,
  input  wire                          res_ready_i,
  output logic                         call_valid_o,
  output logic [ers_pkg::FLOOR_W-1:0]  call_floor_o,
  output logic                         went_free_o,
  output ers_pkg::dir_e                travel_dir_o
);
  import ers_pkg::*;

  localparam int unsigned IW = (FLOORS > 1) ? $clog2(FLOORS) : 1;

  logic [FLOORS-1:0]  pending_q, pending_d;
  logic [FLOOR_W-1:0] car_q, car_d;
  logic [FLOOR_W-1:0] target_q, target_d;
  dir_e               heading_q, heading_d;
  logic               busy_q, busy_d;
  logic               act_q, act_d;

  logic               res_valid_q;
  logic               call_valid_q, call_valid_d;
  logic [FLOOR_W-1:0] call_floor_q, call_floor_d;
  logic               went_free_q, went_free_d;

  logic               fl_ok;
  logic [FLOOR_W-1:0] fl_m1;
  logic [IW-1:0]      fl_idx;

  logic [FLOORS-1:0]  mask_up, mask_dn;
  logic [FLOOR_W-1:0] up_fl, dn_fl, pref_fl, tgt;
  dir_e               nd;

  assign fl_ok  = (ev_floor_i != '0) && ({1'b0, ev_floor_i} <= (FLOOR_W + 1)'(FLOORS));
  assign fl_m1  = ev_floor_i - FLOOR_W'(1);
  assign fl_idx = fl_m1[IW-1:0];

  // event latch: request bits and car floor settle before planning
  always_comb begin
    pending_d = pending_q;
    car_d     = car_q;
    act_d     = act_q;
    if (cmd_i.load) begin
      act_d = fl_ok && ((ev_cmd_i == CMD_REQUEST) || busy_q);
      if (act_d) begin
        if (ev_cmd_i == CMD_REQUEST) begin
          pending_d[fl_idx] = 1'b1;
        end else begin
          if (target_q == ev_floor_i) pending_d[fl_idx] = 1'b0;
          car_d = ev_floor_i;
        end
      end
    end
  end

  // nearest request at or above / at or below the car
  always_comb begin
    up_fl = '0;
    dn_fl = '0;
    for (int i = 0; i < FLOORS; i++) begin
      mask_up[i] = pending_q[i] && ((FLOOR_W + 1)'(i + 1) >= {1'b0, car_q});
      mask_dn[i] = pending_q[i] && ((FLOOR_W + 1)'(i + 1) <= {1'b0, car_q});
    end
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (mask_up[i]) up_fl = FLOOR_W'(i + 1);
    end
    for (int i = 0; i < FLOORS; i++) begin
      if (mask_dn[i]) dn_fl = FLOOR_W'(i + 1);
    end
  end

  always_comb begin
    pref_fl = '0;
    if (heading_q == DIR_UP) pref_fl = up_fl;
    else if (heading_q == DIR_DOWN) pref_fl = dn_fl;
    if (pref_fl != '0) begin
      tgt = pref_fl;
    end else if ((up_fl != '0) &&
                 ((dn_fl == '0) || ((up_fl - car_q) < (car_q - dn_fl)))) begin
      tgt = up_fl;
    end else begin
      tgt = dn_fl;  // ties go down
    end
    nd = heading_q;
    if (tgt != car_q) nd = (tgt > car_q) ? DIR_UP : DIR_DOWN;
  end

  always_comb begin
    target_d     = target_q;
    heading_d    = heading_q;
    busy_d       = busy_q;
    call_valid_d = 1'b0;
    call_floor_d = '0;
    went_free_d  = 1'b0;
    if (act_q) begin
      busy_d   = 1'b1;
      target_d = tgt;
      if (tgt != '0) begin
        if ((nd == heading_q) || (heading_q == DIR_STILL)) begin
          heading_d    = nd;
          call_valid_d = 1'b1;
          call_floor_d = tgt;
        end
      end else begin
        busy_d      = 1'b0;
        heading_d   = DIR_STILL;
        went_free_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      car_q       <= FLOOR_W'(1);
      target_q    <= '0;
      heading_q   <= DIR_STILL;
      busy_q      <= 1'b0;
      act_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
      car_q     <= car_d;
      act_q     <= act_d;
      if (cmd_i.commit) begin
        target_q    <= target_d;
        heading_q   <= heading_d;
        busy_q      <= busy_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      call_valid_q <= call_valid_d;
      call_floor_q <= call_floor_d;
      went_free_q  <= went_free_d;
    end
  end

  assign status_o.can_commit = !res_valid_q || res_ready_i;
  assign res_valid_o  = res_valid_q;
  assign call_valid_o = call_valid_q;
  assign call_floor_o = call_floor_q;
  assign went_free_o  = went_free_q;
  assign travel_dir_o = heading_q;

endmodule

`default_nettype wire

@@ rtl/elevator_request_scheduler.sv @@
`default_nettype none
// channel | dir | tdata (lsb up)                                    | tuser
// s_axis  | in  | floor_num[4:0], zero pad to 8                     | cmd
// m_axis  | out | call_valid, call_floor[4:0], went_free, travel_dir[1:0], pad to 16 | -
//
// Each event is first latched into the request bits (ST_IDLE), then the
// planner (up/down priority encoders plus distance compare) commits it (ST_PLAN).
// The result word sits in an output register; the next event is taken
// while it waits, but its plan holds until that word is drained.
// Reset clears all requests, puts the car at floor 1, free and motionless.

module elevator_request_scheduler #(
  parameter int unsigned FLOORS = ers_pkg::FLOORS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [ers_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // floor_num
  input  wire                              s_axis_tuser,   // cmd
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [ers_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // call_valid, call_floor,
                                                           // went_free, travel_dir
);
  import ers_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               call_valid;
  logic [FLOOR_W-1:0] call_floor;
  logic               went_free;
  dir_e               travel_dir;

  ers_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ers_datapath #(
    .FLOORS (FLOORS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .ev_cmd_i     (s_axis_tuser),
    .ev_floor_i   (s_axis_tdata[FLOOR_W-1:0]),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .call_valid_o (call_valid),
    .call_floor_o (call_floor),
    .went_free_o  (went_free),
    .travel_dir_o (travel_dir)
  );

  assign m_axis_tdata = {(OUT_DATA_W - 9)'(0), travel_dir, went_free, call_floor, call_valid};

  // a plan never overwrites an undrained word
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("plan committed over a pending result");

  // an accepted event always goes through the planning state
  a_accept_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("event accepted without planning");

  // a call and going free are exclusive, and a call names a floor
  a_call_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && call_valid) |-> (!went_free && (call_floor != '0)))
    else $error("inconsistent result word");

  // going free leaves the car motionless
  a_free_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && went_free) |-> (travel_dir == DIR_STILL))
    else $error("went free while moving");

endmodule

`default_nettype wire
